>>> sv/lpr_pkg.sv
package lpr_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int PORT_COUNT    = 16;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = IDX_W + 1;
  localparam int ADDR_W        = 32;
  localparam int PORT_W        = 4;
  localparam int STATUS_W      = 2;

  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);

  localparam logic FUNC_APPEND = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_STORED = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FOUND  = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NONE   = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0] prefix;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] hop;
    logic [PORT_W-1:0] port;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic clear;   // start of a new lookup
    logic valid;   // read data holds a live entry
  } scan_ctl_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] hop;
    logic [PORT_W-1:0] port;
  } scan_res_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

endpackage

>>> sv/longest_prefix_route_lookup_top.sv
// Append: the result strobes in the cycle after start is taken, busy stays low.
// Lookup: the FSM steps S_SCAN then S_DRAIN, and the result strobes after S_DRAIN (in the
// cycle after start if empty); busy is high until that strobe, so lookups never overlap.
// The scan reads one route per cycle from the single route memory's read port.
// Synchronous reset empties the table (count to zero); route memory contents are not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle on done.
module longest_prefix_route_lookup_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           func,
  input  logic [lpr_pkg::ADDR_W-1:0]     lookup_address,
  input  logic [lpr_pkg::ADDR_W-1:0]     entry_prefix,
  input  logic [lpr_pkg::ADDR_W-1:0]     entry_mask,
  input  logic [lpr_pkg::ADDR_W-1:0]     entry_next_hop,
  input  logic [lpr_pkg::PORT_W-1:0]     entry_port,
  output logic                           done,
  output logic [lpr_pkg::STATUS_W-1:0]   status,
  output logic [lpr_pkg::ADDR_W-1:0]     hop_address,
  output logic [lpr_pkg::PORT_W-1:0]     out_port
);

  lpr_pkg::state_t            state;
  logic [lpr_pkg::CNT_W-1:0]  entry_count;
  logic [lpr_pkg::IDX_W-1:0]  rd_idx;
  logic                       rd_valid;
  logic [lpr_pkg::ADDR_W-1:0] lookup_addr;

  logic                       accept;
  logic                       app_acc;
  logic                       lkp_acc;
  logic                       full;
  logic                       empty;
  logic                       last_issue;
  lpr_pkg::entry_t            wr_entry;
  logic [lpr_pkg::ENTRY_W-1:0] rd_data;
  lpr_pkg::scan_ctl_t         ctl;
  lpr_pkg::scan_res_t         res;

  assign busy       = (state != lpr_pkg::S_IDLE);
  assign accept     = start && !busy;
  assign app_acc    = accept && (func == lpr_pkg::FUNC_APPEND);
  assign lkp_acc    = accept && (func == lpr_pkg::FUNC_LOOKUP);
  assign full       = (entry_count == lpr_pkg::CNT_FULL);
  assign empty      = (entry_count == '0);
  assign last_issue = ({1'b0, rd_idx} == (entry_count - lpr_pkg::CNT_ONE));

  always_comb begin
    wr_entry.prefix = entry_prefix;
    wr_entry.mask   = entry_mask;
    wr_entry.hop    = entry_next_hop;
    wr_entry.port   = entry_port;
  end

  // appends are refused while busy, so writes never overlap a scan
  lpr_ram #(
    .WIDTH (lpr_pkg::ENTRY_W),
    .DEPTH (lpr_pkg::TABLE_ENTRIES)
  ) u_route_ram (
    .clk   (clk),
    .we    (app_acc && !full),
    .waddr (entry_count[lpr_pkg::IDX_W-1:0]),
    .wdata (wr_entry),
    .raddr (rd_idx),
    .rdata (rd_data)
  );

  assign ctl.clear = lkp_acc;
  assign ctl.valid = rd_valid;

  lpr_scan u_scan (
    .clk         (clk),
    .ctl         (ctl),
    .lookup_addr (lookup_addr),
    .entry       (lpr_pkg::entry_t'(rd_data)),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= lpr_pkg::S_IDLE;
      entry_count <= '0;
      rd_idx      <= '0;
      rd_valid    <= 1'b0;
    end else begin
      rd_valid <= (state == lpr_pkg::S_SCAN);
      if (app_acc && !full) begin
        entry_count <= entry_count + lpr_pkg::CNT_ONE;
      end
      unique case (state)
        lpr_pkg::S_IDLE: begin
          rd_idx <= '0;
          if (lkp_acc && !empty) begin
            state <= lpr_pkg::S_SCAN;
          end
        end
        lpr_pkg::S_SCAN: begin
          if (last_issue) begin
            state <= lpr_pkg::S_DRAIN;
          end else begin
            rd_idx <= rd_idx + lpr_pkg::IDX_W'(1);
          end
        end
        lpr_pkg::S_DRAIN: begin
          state <= lpr_pkg::S_IDLE;
        end
        default: begin
          state <= lpr_pkg::S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (lkp_acc) begin
      lookup_addr <= lookup_address;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= app_acc || (lkp_acc && empty) || (state == lpr_pkg::S_DRAIN);
    end
  end

  always_ff @(posedge clk) begin
    if (app_acc) begin
      status      <= full ? lpr_pkg::STAT_FULL : lpr_pkg::STAT_STORED;
      hop_address <= '0;
      out_port    <= '0;
    end else if (lkp_acc) begin
      status      <= lpr_pkg::STAT_NONE;
      hop_address <= '0;
      out_port    <= '0;
    end else if (state == lpr_pkg::S_DRAIN) begin
      status      <= res.found ? lpr_pkg::STAT_FOUND : lpr_pkg::STAT_NONE;
      hop_address <= res.hop;
      out_port    <= res.port;
    end
  end

endmodule

>>> sv/lpr_ram.sv
module lpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/lpr_scan.sv
module lpr_scan (
  input  logic                      clk,
  input  lpr_pkg::scan_ctl_t        ctl,
  input  logic [lpr_pkg::ADDR_W-1:0] lookup_addr,
  input  lpr_pkg::entry_t           entry,
  output lpr_pkg::scan_res_t        res
);

  logic                       found;
  logic [lpr_pkg::ADDR_W-1:0] best_mask;
  logic [lpr_pkg::ADDR_W-1:0] best_hop;
  logic [lpr_pkg::PORT_W-1:0] best_port;
  logic                       take;

  // strict greater keeps the earliest slot on equal masks
  assign take = ctl.valid && ((lookup_addr & entry.mask) == entry.prefix) &&
                (!found || (entry.mask > best_mask));

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      found <= 1'b0;
    end else if (take) begin
      found     <= 1'b1;
      best_mask <= entry.mask;
      best_hop  <= entry.hop;
      best_port <= entry.port;
    end
  end

  // winner including the entry on the read port this cycle
  always_comb begin
    res.found = take || found;
    res.hop   = '0;
    res.port  = '0;
    if (take) begin
      res.hop  = entry.hop;
      res.port = entry.port;
    end else if (found) begin
      res.hop  = best_hop;
      res.port = best_port;
    end
  end

endmodule

>>> sv/lpr_check.sv
module lpr_check (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         func,
  input logic [lpr_pkg::ADDR_W-1:0]   lookup_address,
  input logic [lpr_pkg::ADDR_W-1:0]   entry_prefix,
  input logic [lpr_pkg::ADDR_W-1:0]   entry_mask,
  input logic [lpr_pkg::ADDR_W-1:0]   entry_next_hop,
  input logic [lpr_pkg::PORT_W-1:0]   entry_port,
  input logic                         done,
  input logic [lpr_pkg::STATUS_W-1:0] status,
  input logic [lpr_pkg::ADDR_W-1:0]   hop_address,
  input logic [lpr_pkg::PORT_W-1:0]   out_port
);

  // a taken request either answers next cycle or starts a scan
  a_req_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("request neither answered nor scanning");

  // end of a scan always carries its result
  a_busy_end: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("scan ended without a result");

  a_no_result_while_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobed during a scan");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (done && (status != lpr_pkg::STAT_FOUND)) |-> ((hop_address == '0) && (out_port == '0)))
    else $error("nonzero hop or port without a route");

  // an append answers in the very next cycle with a table status
  a_append_status: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (func == lpr_pkg::FUNC_APPEND)) |=>
      (done && ((status == lpr_pkg::STAT_STORED) || (status == lpr_pkg::STAT_FULL))))
    else $error("append gave wrong status");

endmodule

bind longest_prefix_route_lookup_top lpr_check u_lpr_check (.*);
